>>> rtl/core/kconv2d_pkg.sv
package kconv2d_pkg;

    // Default geometry
    localparam int KERNEL_SIZE_DEF = 5;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 4096;

    // Tap grid as laid out in the coefficient registers
    localparam int TAP_GRID  = 5;
    localparam int TAP_COUNT = TAP_GRID * TAP_GRID;
    localparam int TAPS_PER_WORD = 4;

    // Datapath widths
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 11;
    localparam int PROD_W    = COEF_W + PIX_W + 1;
    localparam int RSUM_W    = PROD_W + 3;
    localparam int TSUM_W    = RSUM_W + 3;

    localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // Result queue depth, also the number of results that may be outstanding
    localparam int OUT_DEPTH = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int FS_FIELD_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_BASE = 3'd1;

    // Operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } t_out_item;

endpackage

>>> rtl/core/kernel_convolution_2d.sv
// Streaming 2D correlation of an 8-bit grayscale frame with a signed Q5.11
// kernel of KERNEL_SIZE x KERNEL_SIZE taps, taken centered from a 5x5 grid.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data):
// index 0 sets width-1 and height-1 and restarts the frame; indexes 1..7 load
// the coefficient words. Write only while no transaction is in flight.
// Input channel (i_in_valid/o_in_stall): one pixel or drain transaction in
// raster order; pixels outside the frame read as zero. Output channel
// (o_out_valid/i_out_stall): one filtered pixel per window position, with
// frame_end on the bottom-right one.
// Throughput: one input transaction per clock while o_in_stall is low. A
// transaction that completes a window passes the memory read, window update,
// products, row sums, total and result queue registers to o_out_valid.
// Up to eight results may be outstanding in the pipeline and the result
// queue; when the receiver stalls long enough to fill them, o_in_stall rises
// until results are taken. A stalled result holds in the queue.
// Reset (synchronous, i_rst_n low) clears the counters, the configuration,
// the pipeline and the queue; both o_in_stall and a low o_cfg_ready hold off
// traffic while it is asserted. The line store needs no clearing pass.
module kernel_convolution_2d #(
    parameter int KERNEL_SIZE = kconv2d_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = kconv2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = kconv2d_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [kconv2d_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kconv2d_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  kconv2d_pkg::t_in_item              i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output kconv2d_pkg::t_out_item             o_out_data
);
    import kconv2d_pkg::*;

    localparam int LO        = KERNEL_SIZE / 2;
    localparam int REACH     = KERNEL_SIZE - 1 - LO;
    localparam int TAP_START = 2 - LO;
    localparam int NUM_BANKS = KERNEL_SIZE + 1;
    localparam int HEADS     = (REACH > 0) ? REACH : 1;
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int CXW       = CW + 1;
    localparam int IRW       = $clog2(MAX_HEIGHT + 1);
    localparam int ORW       = $clog2(MAX_HEIGHT);
    localparam int RXW       = ORW + 1;
    localparam int RVW       = ORW + 2;
    localparam int BKW       = $clog2(NUM_BANKS);
    localparam int TBW       = BKW + 2;
    localparam int QW        = TSUM_W - FRAC_BITS;
    localparam int OPW       = $clog2(OUT_DEPTH);
    localparam int UW        = $clog2(OUT_DEPTH + 1);

    // Configuration state
    logic [CW-1:0]               r_w_last;
    logic [ORW-1:0]              r_h_last;
    logic signed [COEF_W-1:0]    r_taps [TAP_COUNT];

    // Frame position counters
    logic [CW-1:0]               r_in_col;
    logic [IRW-1:0]              r_in_row;
    logic [BKW-1:0]              r_in_bank;
    logic [CW-1:0]               r_out_col;
    logic [ORW-1:0]              r_out_row;
    logic [BKW-1:0]              r_out_bank;

    // Line store banks and head columns of each stored row
    logic [PIX_W-1:0]            r_line_mem [NUM_BANKS][MAX_WIDTH];
    logic [PIX_W-1:0]            r_rd [NUM_BANKS];
    logic [PIX_W-1:0]            r_head [NUM_BANKS][HEADS];

    // Stage A: fetch control
    logic                        r_a_valid;
    logic                        r_a_last;
    logic                        r_a_row_start;
    logic                        r_a_col_ok;
    logic [KERNEL_SIZE-1:0]      r_a_row_ok;
    logic [BKW-1:0]              r_a_row_bank [KERNEL_SIZE];
    logic [HEADS-1:0]            r_a_head_ok;
    logic                        r_byp;
    logic [BKW-1:0]              r_byp_bank;
    logic [PIX_W-1:0]            r_byp_pix;

    // Stage B: window
    logic                        r_b_valid;
    logic                        r_b_last;
    logic [PIX_W-1:0]            r_win [KERNEL_SIZE][KERNEL_SIZE];

    // Stages C, D, E: products, row sums, total
    logic                        r_c_valid;
    logic                        r_c_last;
    logic signed [PROD_W-1:0]    r_prod [KERNEL_SIZE][KERNEL_SIZE];
    logic                        r_d_valid;
    logic                        r_d_last;
    logic signed [RSUM_W-1:0]    r_rsum [KERNEL_SIZE];
    logic                        r_e_valid;
    logic                        r_e_last;
    logic signed [TSUM_W-1:0]    r_e_sum;

    // Result queue
    t_out_item                   r_fifo [OUT_DEPTH];
    logic [OPW-1:0]              r_wr_ptr;
    logic [OPW-1:0]              r_rd_ptr;
    logic [UW-1:0]               r_count;
    logic [UW-1:0]               r_used;

    // Next values and decode
    logic                        cfg_we;
    logic                        in_acc;
    logic                        in_open;
    logic                        pix_wr;
    logic [CW-1:0]               n_in_col;
    logic [IRW-1:0]              n_in_row;
    logic [BKW-1:0]              n_in_bank;
    logic [RXW-1:0]              out_row_reach;
    logic [RXW-1:0]              need_r;
    logic [CXW-1:0]              out_col_reach;
    logic [CXW-1:0]              need_c;
    logic                        ready;
    logic                        emit;
    logic                        is_last;
    logic [CW-1:0]               rd_addr;
    logic                        col_ok;
    logic [KERNEL_SIZE-1:0]      row_ok;
    logic [BKW-1:0]              row_bank [KERNEL_SIZE];
    logic [HEADS-1:0]            head_ok;
    logic [CW-1:0]               cfg_w_last;
    logic [ORW-1:0]              cfg_h_last;
    logic [PIX_W-1:0]            bank_px [NUM_BANKS];
    logic [PIX_W-1:0]            fetch_px [KERNEL_SIZE];
    logic [PIX_W-1:0]            head_px [KERNEL_SIZE][HEADS];
    logic [PIX_W-1:0]            n_win [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0]    n_prod [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [RSUM_W-1:0]    n_rsum [KERNEL_SIZE];
    logic signed [TSUM_W-1:0]    n_tsum;
    logic [QW-1:0]               quot;
    t_out_item                   n_result;
    logic                        fifo_pop;

    // Handshakes
    assign o_cfg_ready = i_rst_n;
    assign o_in_stall  = !i_rst_n || (r_used == UW'(OUT_DEPTH));
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && !o_in_stall;

    // Saturate the frame size fields to the store geometry
    always_comb begin
        if (i_cfg_data[FS_FIELD_W-1:0] > FS_FIELD_W'(MAX_WIDTH - 1)) begin
            cfg_w_last = CW'(MAX_WIDTH - 1);
        end else begin
            cfg_w_last = i_cfg_data[CW-1:0];
        end
        if (i_cfg_data[2*FS_FIELD_W-1:FS_FIELD_W] > FS_FIELD_W'(MAX_HEIGHT - 1)) begin
            cfg_h_last = ORW'(MAX_HEIGHT - 1);
        end else begin
            cfg_h_last = i_cfg_data[FS_FIELD_W+ORW-1:FS_FIELD_W];
        end
    end

    // Advance the input position on a pixel that still belongs to the frame
    always_comb begin
        in_open   = RXW'(r_in_row) <= RXW'(r_h_last);
        pix_wr    = in_acc && (i_in_data.operation == OP_PIXEL) && in_open;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_bank = r_in_bank;
        if (pix_wr) begin
            if (r_in_col == r_w_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + IRW'(1);
                if (r_in_bank == BKW'(NUM_BANKS - 1)) begin
                    n_in_bank = '0;
                end else begin
                    n_in_bank = r_in_bank + BKW'(1);
                end
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
    end

    // Decide whether the next output window is complete
    always_comb begin
        out_row_reach = RXW'(r_out_row) + RXW'(REACH);
        need_r = (out_row_reach > RXW'(r_h_last)) ? RXW'(r_h_last) : out_row_reach;
        out_col_reach = CXW'(r_out_col) + CXW'(REACH);
        need_c = (out_col_reach > CXW'(r_w_last)) ? CXW'(r_w_last) : out_col_reach;
        ready = (RXW'(n_in_row) > need_r) ||
                ((RXW'(n_in_row) == need_r) && (CXW'(n_in_col) > need_c));
        emit    = in_acc && ready;
        is_last = (r_out_row == r_h_last) && (r_out_col == r_w_last);
        col_ok  = out_col_reach <= CXW'(r_w_last);
        rd_addr = out_col_reach[CW-1:0];
    end

    // Map window rows to banks and flag rows inside the frame
    always_comb begin
        logic [TBW-1:0] bsum;
        logic [RVW-1:0] rpos;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            bsum = TBW'(r_out_bank) + TBW'(k + NUM_BANKS - LO);
            if (bsum >= TBW'(2 * NUM_BANKS)) begin
                bsum = bsum - TBW'(2 * NUM_BANKS);
            end else if (bsum >= TBW'(NUM_BANKS)) begin
                bsum = bsum - TBW'(NUM_BANKS);
            end
            row_bank[k] = bsum[BKW-1:0];
            rpos = RVW'(r_out_row) + RVW'(k);
            row_ok[k] = (rpos >= RVW'(LO)) && (rpos <= RVW'(r_h_last) + RVW'(LO));
        end
        for (int h = 0; h < HEADS; h++) begin
            head_ok[h] = CXW'(h) <= CXW'(r_w_last);
        end
    end

    // Configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last   <= '0;
            r_h_last   <= '0;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_bank  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_bank <= '0;
        end else if (cfg_we) begin
            if (i_cfg_index == CFG_FRAME_SIZE) begin
                r_w_last   <= cfg_w_last;
                r_h_last   <= cfg_h_last;
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_bank  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_bank <= '0;
            end
        end else if (emit && is_last) begin
            // restart the frame after the bottom-right output
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_bank  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_bank <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_in_bank <= n_in_bank;
            if (emit) begin
                if (r_out_col == r_w_last) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + ORW'(1);
                    if (r_out_bank == BKW'(NUM_BANKS - 1)) begin
                        r_out_bank <= '0;
                    end else begin
                        r_out_bank <= r_out_bank + BKW'(1);
                    end
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    // Load coefficient taps, four per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAP_COUNT; t++) begin
                r_taps[t] <= '0;
            end
        end else if (cfg_we) begin
            for (int t = 0; t < TAP_COUNT; t++) begin
                if (i_cfg_index == CFG_COEFF_BASE + CFG_IDX_W'(t / TAPS_PER_WORD)) begin
                    r_taps[t] <= i_cfg_data[COEF_W*(t % TAPS_PER_WORD) +: COEF_W];
                end
            end
        end
    end

    // Line store banks: write the incoming pixel, read the new window column
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        always_ff @(posedge i_clk) begin
            if (pix_wr && (r_in_bank == BKW'(b))) begin
                r_line_mem[b][r_in_col] <= i_in_data.pixel_in;
            end
            if (in_acc) begin
                r_rd[b] <= r_line_mem[b][rd_addr];
            end
        end

        // Keep the first columns of each row for the window reload at row start
        always_ff @(posedge i_clk) begin
            for (int h = 0; h < HEADS; h++) begin
                if (pix_wr && (h < REACH) && (r_in_bank == BKW'(b)) &&
                    (r_in_col == CW'(h))) begin
                    r_head[b][h] <= i_in_data.pixel_in;
                end
            end
        end
    end

    // Stage A registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_last      <= is_last;
            r_a_row_start <= (r_out_col == '0);
            r_a_col_ok    <= col_ok;
            r_a_row_ok    <= row_ok;
            r_a_head_ok   <= head_ok;
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                r_a_row_bank[k] <= row_bank[k];
            end
            // forward a pixel written to the address read in the same cycle
            r_byp      <= pix_wr && (r_in_col == rd_addr);
            r_byp_bank <= r_in_bank;
            r_byp_pix  <= i_in_data.pixel_in;
        end
    end

    // Assemble the new window column and the row-start reload
    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            bank_px[b] = (r_byp && (r_byp_bank == BKW'(b))) ? r_byp_pix : r_rd[b];
        end
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            fetch_px[k] = (r_a_row_ok[k] && r_a_col_ok) ? bank_px[r_a_row_bank[k]] : PIX_MIN;
            for (int h = 0; h < HEADS; h++) begin
                head_px[k][h] = (r_a_row_ok[k] && r_a_head_ok[h]) ?
                                r_head[r_a_row_bank[k]][h] : PIX_MIN;
            end
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                if (r_a_row_start) begin
                    if (j < LO) begin
                        n_win[k][j] = PIX_MIN;
                    end else if (j - LO < REACH) begin
                        n_win[k][j] = head_px[k][(j - LO < HEADS) ? (j - LO) : 0];
                    end else begin
                        n_win[k][j] = fetch_px[k];
                    end
                end else if (j < KERNEL_SIZE - 1) begin
                    n_win[k][j] = r_win[k][j + 1];
                end else begin
                    n_win[k][j] = fetch_px[k];
                end
            end
        end
    end

    // Multiply each window pixel by its tap
    always_comb begin
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                n_prod[k][j] = r_taps[(TAP_START + k) * TAP_GRID + TAP_START + j] *
                               $signed({1'b0, r_win[k][j]});
            end
        end
    end

    // Sum each row, then the rows
    always_comb begin
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            n_rsum[k] = '0;
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                n_rsum[k] = n_rsum[k] + RSUM_W'(r_prod[k][j]);
            end
        end
        n_tsum = '0;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            n_tsum = n_tsum + TSUM_W'(r_rsum[k]);
        end
    end

    // Advance the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_b_last <= r_a_last;
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                for (int j = 0; j < KERNEL_SIZE; j++) begin
                    r_win[k][j] <= n_win[k][j];
                end
            end
        end
        r_c_last <= r_b_last;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                r_prod[k][j] <= n_prod[k][j];
            end
        end
        r_d_last <= r_c_last;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            r_rsum[k] <= n_rsum[k];
        end
        r_e_last <= r_d_last;
        r_e_sum  <= n_tsum;
    end

    // Truncate toward zero and clamp to the pixel range
    always_comb begin
        quot = r_e_sum[TSUM_W-1:FRAC_BITS];
        if (r_e_sum[TSUM_W-1] || (r_e_sum == '0)) begin
            n_result.pixel_out = PIX_MIN;
        end else if (quot > QW'(PIX_MAX)) begin
            n_result.pixel_out = PIX_MAX;
        end else begin
            n_result.pixel_out = quot[PIX_W-1:0];
        end
        n_result.frame_end = r_e_last;
    end

    // Result queue and outstanding result count
    assign fifo_pop    = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (r_e_valid) begin
            r_fifo[r_wr_ptr] <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_used   <= '0;
        end else begin
            if (r_e_valid) begin
                r_wr_ptr <= r_wr_ptr + OPW'(1);
            end
            if (fifo_pop) begin
                r_rd_ptr <= r_rd_ptr + OPW'(1);
            end
            r_count <= r_count + UW'(r_e_valid) - UW'(fifo_pop);
            r_used  <= r_used + UW'(emit) - UW'(fifo_pop);
        end
    end

endmodule

>>> rtl/core/kconv2d_check.sv
module kconv2d_check (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   o_in_stall,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  kconv2d_pkg::t_out_item o_out_data
);
    import kconv2d_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // A result only appears a fixed pipeline depth after an accepted transaction
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 6))
        else $error("result without matching transaction");

    // Back-pressure only when results are waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind kernel_convolution_2d kconv2d_check u_kconv2d_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
